// ----- hdl/sample_until_duplicate_counter_macros.svh -----
// Assertion macros shared by the sample-until-duplicate counter.
`ifndef SAMPLE_UNTIL_DUPLICATE_COUNTER_MACROS_SVH
`define SAMPLE_UNTIL_DUPLICATE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample_until_duplicate_counter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SUDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample_until_duplicate_counter: next-cycle check failed");

`endif

// ----- hdl/sudc_pkg.sv -----
// Package with the types and constants of the sample-until-duplicate counter.
package sudc_pkg;

  localparam int POPULATION = 65536;
  localparam int MAP_DEPTH  = 65536;
  localparam int IDX_W      = 16;
  localparam int CNT_W      = 17;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK
  } state_t;

endpackage

// ----- hdl/sudc_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module sudc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sample_until_duplicate_counter.sv -----
// Sample-until-duplicate counter: bitmap lookup, marked list and clear walk.
// A result is registered from the lookup state once the output slot is free;
// a new beat is taken only when idle, after the last beat's bitmap read-modify-write.
// After a duplicate the clear walk over the marked list holds off input until
// every marked index has been cleared in the bitmap.
// Reset: a clearing pass writes all 65536 bitmap entries, one per cycle, before
// the first beat is accepted; counters and handshake state reset at once.
`include "sample_until_duplicate_counter_macros.svh"

module sample_until_duplicate_counter
  import sudc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_sample_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_duplicate,
  output logic [CNT_W-1:0] out_draw_count
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  marked_total_r, marked_total_nxt;
  logic [CNT_W-1:0]  run_draws_r, run_draws_nxt;
  logic [CNT_W-1:0]  walk_k_r, walk_k_nxt;
  logic              walk_v_r, walk_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_dup_r, out_dup_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic [IDX_W-1:0]  idx_clamped;
  logic [CNT_W-1:0]  count;
  logic              slot_free;
  logic              walk_done;
  logic              in_accept;

  logic              bm_we, bm_wdata, bm_re, bm_rdata;
  logic [ADDR_W-1:0] bm_waddr, bm_raddr;
  logic              ml_we, ml_re;
  logic [ADDR_W-1:0] ml_waddr, ml_raddr;
  logic [IDX_W-1:0]  ml_wdata, ml_rdata;

  sudc_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  sudc_ram #(.WIDTH(IDX_W), .DEPTH(MAP_DEPTH)) u_marked_list (
    .clk   (clk),
    .we    (ml_we),
    .waddr (ml_waddr),
    .wdata (ml_wdata),
    .re    (ml_re),
    .raddr (ml_raddr),
    .rdata (ml_rdata)
  );

  assign idx_clamped = ({16'b0, in_sample_index} >= 32'(POPULATION)) ?
                       IDX_W'(POPULATION - 1) : in_sample_index;
  assign count       = run_draws_r + CNT_W'(1);
  assign slot_free   = !out_valid_r || out_ready;
  assign walk_done   = (walk_k_r >= marked_total_r) && !walk_v_r;
  assign in_ready    = (state_r == ST_IDLE);
  assign in_accept   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;
  assign out_draw_count   = out_cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (clr_addr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          state_nxt = bm_rdata ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    clr_addr_nxt     = clr_addr_r;
    marked_total_nxt = marked_total_r;
    run_draws_nxt    = run_draws_r;
    walk_k_nxt       = walk_k_r;
    walk_v_nxt       = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_dup_nxt      = out_dup_r;
    out_cnt_nxt      = out_cnt_r;
    idx_nxt          = idx_r;
    bm_we            = 1'b0;
    bm_waddr         = idx_r;
    bm_wdata         = 1'b0;
    bm_re            = 1'b0;
    bm_raddr         = idx_clamped;
    ml_we            = 1'b0;
    ml_waddr         = marked_total_r[ADDR_W-1:0];
    ml_wdata         = idx_r;
    ml_re            = 1'b0;
    ml_raddr         = walk_k_r[ADDR_W-1:0];
    unique case (state_r)
      ST_INIT: begin
        bm_we        = 1'b1;
        bm_waddr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_accept) begin
          bm_re   = 1'b1;
          idx_nxt = idx_clamped;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = bm_rdata;
          out_cnt_nxt   = count;
          walk_k_nxt    = '0;
          if (!bm_rdata) begin
            bm_we         = 1'b1;
            bm_wdata      = 1'b1;
            run_draws_nxt = count;
            if (marked_total_r < CNT_W'(MAP_DEPTH)) begin
              ml_we            = 1'b1;
              marked_total_nxt = marked_total_r + CNT_W'(1);
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_k_r < marked_total_r) begin
          ml_re      = 1'b1;
          walk_k_nxt = walk_k_r + CNT_W'(1);
          walk_v_nxt = 1'b1;
        end
        if (walk_v_r) begin
          bm_we    = 1'b1;
          bm_waddr = ml_rdata;
        end
        if (walk_done) begin
          marked_total_nxt = '0;
          run_draws_nxt    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      clr_addr_r     <= '0;
      marked_total_r <= '0;
      run_draws_r    <= '0;
      walk_k_r       <= '0;
      walk_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      marked_total_r <= marked_total_nxt;
      run_draws_r    <= run_draws_nxt;
      walk_k_r       <= walk_k_nxt;
      walk_v_r       <= walk_v_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    out_dup_r <= out_dup_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  `SUDC_ASSERT_SAME(a_bitmap_no_rw_clash, clk, rst_n, bm_re, !bm_we)
  `SUDC_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, in_accept, state_r == ST_LOOKUP)
  `SUDC_ASSERT_NEXT(a_dup_starts_walk, clk, rst_n,
    (state_r == ST_LOOKUP) && slot_free && bm_rdata, (state_r == ST_WALK) && out_is_duplicate)
  `SUDC_ASSERT_SAME(a_walk_in_range, clk, rst_n, state_r == ST_WALK,
    walk_k_r <= marked_total_r)

endmodule
